### rtl/core/pwg_pkg.sv
// Shared types, constants and register codes for the horizontal Prewitt gradient block.
package pwg_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int WIDTH_RST      = 320;
    localparam int HEIGHT_RST     = 240;
    localparam int MIN_DIM        = 3;
    localparam int CFG_FIELD_W    = 11;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int CHAN_W         = 8;
    localparam int PIX_W          = 3 * CHAN_W;
    localparam int SUM_W          = CHAN_W + 2;
    localparam int PROD_W         = 2 * SUM_W;
    // floor(d/3) == (d*683) >> 11 for every d up to 765
    localparam int DIV3_MUL       = 683;
    localparam int DIV3_SHIFT     = 11;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_DRAIN = 1'b1
    } t_func;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_func             func;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              frame_last;
    } t_out_beat;

    // Edge handling and emit flags of one window position
    typedef struct packed {
        logic emit;
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
        logic frame_last;
    } t_edge_ctl;

endpackage

### rtl/core/pwg_cfg.sv
// APB register file holding frame width, height and the derived pixel total.
module pwg_cfg
    import pwg_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int EW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [WW-1:0]         o_width,
    output logic [HW-1:0]         o_height,
    output logic [EW-1:0]         o_total,
    output logic                  o_restart
);

    localparam int W_RST = (WIDTH_RST < MAX_WIDTH) ? WIDTH_RST : MAX_WIDTH;
    localparam int H_RST = (HEIGHT_RST < MAX_HEIGHT) ? HEIGHT_RST : MAX_HEIGHT;

    function automatic logic [31:0] sat_dim(input logic [CFG_FIELD_W-1:0] v, input int hi);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'(MIN_DIM)) begin
            x = 32'(MIN_DIM);
        end
        if (x > 32'(hi)) begin
            x = 32'(hi);
        end
        return x;
    endfunction

    logic [WW-1:0]    r_width, n_width;
    logic [HW-1:0]    r_height, n_height;
    logic [EW-1:0]    r_total, n_total;
    logic [WW+HW-1:0] prod;
    logic             wr;
    t_reg_idx         idx;

    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (wr) begin
            case (idx)
                REG_WIDTH:  n_width  = WW'(sat_dim(pwdata[CFG_FIELD_W-1:0], MAX_WIDTH));
                REG_HEIGHT: n_height = HW'(sat_dim(pwdata[CFG_FIELD_W-1:0], MAX_HEIGHT));
                default: ;
            endcase
        end
        prod    = {{HW{1'b0}}, n_width} * {{WW{1'b0}}, n_height};
        n_total = prod[EW-1:0];
    end

    always_comb begin
        case (idx)
            REG_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(W_RST);
            r_height <= HW'(H_RST);
            r_total  <= EW'(W_RST * H_RST);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_total  <= n_total;
        end
    end

    assign o_width   = r_width;
    assign o_height  = r_height;
    assign o_total   = r_total;
    assign o_restart = wr;

endmodule

### rtl/core/pwg_line_mem.sv
// Simple dual-port line store: one write port, one registered read port.
module pwg_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold the last read while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/pwg_seq.sv
// Input sequencer: raster counters, edge flags, line store read-modify-write with forwarding.
module pwg_seq
    import pwg_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int EW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WW-1:0]    i_width,
    input  logic [HW-1:0]    i_height,
    input  logic [EW-1:0]    i_total,
    input  logic             i_restart,
    input  logic             i_in_valid,
    input  t_in_beat         i_in,
    output logic             o_in_ready,
    input  logic             i_b_free,
    output logic             o_rd_en,
    output logic [CW-1:0]    o_rd_addr,
    input  logic [2*PIX_W-1:0] i_rd_data,
    output logic             o_wr_en,
    output logic [CW-1:0]    o_wr_addr,
    output logic [2*PIX_W-1:0] o_wr_data,
    output logic             o_a_adv,
    output t_pix             o_top,
    output t_pix             o_mid,
    output t_pix             o_bot,
    output t_edge_ctl        o_ctl
);

    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [EW-1:0]      r_emitted;
    logic               r_a_valid;
    logic [CW-1:0]      r_a_addr;
    t_pix               r_a_bot;
    t_edge_ctl          r_a_ctl;
    logic               r_fwd;
    logic [2*PIX_W-1:0] r_fwd_data;

    logic               a_adv, accept, take, done, drain;
    logic [31:0]        c32, r32, h32;
    t_pix               bot;
    t_edge_ctl          ctl;
    logic [2*PIX_W-1:0] eff;

    assign a_adv      = r_a_valid && i_b_free;
    assign o_in_ready = !r_a_valid || i_b_free;
    assign accept     = i_in_valid && o_in_ready;

    assign c32   = 32'(r_col);
    assign r32   = 32'(r_row);
    assign h32   = 32'(i_height);
    assign done  = r32 >= h32;
    assign drain = i_in.func == FUNC_DRAIN;
    // drop a drain that arrives before the frame's last pixel
    assign take  = accept && !(drain && !done);
    assign bot   = done ? '0 : {i_in.red_in, i_in.green_in, i_in.blue_in};

    // window center sits one column behind the incoming pixel, wrapping to the previous row
    always_comb begin
        ctl.emit       = (r32 >= 32'd2) || (r32 == 32'd1 && c32 >= 32'd1);
        ctl.row_top    = (c32 == 32'd0) ? (r32 == 32'd2) : (r32 == 32'd1);
        ctl.row_bot    = (c32 == 32'd0) ? (r32 == h32 + 32'd1) : (r32 == h32);
        ctl.col_left   = c32 == 32'd1;
        ctl.col_right  = c32 == 32'd0;
        ctl.frame_last = ctl.emit && (32'(r_emitted) + 32'd1 >= 32'(i_total));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_emitted <= '0;
        end else if (i_restart || (take && ctl.frame_last)) begin
            r_col     <= '0;
            r_row     <= '0;
            r_emitted <= '0;
        end else if (take) begin
            if (ctl.emit) begin
                r_emitted <= r_emitted + EW'(1);
            end
            if (c32 + 32'd1 >= 32'(i_width)) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else if (take) begin
            r_a_valid <= 1'b1;
            // same entry written back this cycle: the read returns stale data
            r_fwd     <= a_adv && (r_col == r_a_addr);
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_addr   <= r_col;
            r_a_bot    <= bot;
            r_a_ctl    <= ctl;
            r_fwd_data <= o_wr_data;
        end
    end

    assign eff       = r_fwd ? r_fwd_data : i_rd_data;
    assign o_rd_en   = take;
    assign o_rd_addr = r_col;
    assign o_wr_en   = a_adv;
    assign o_wr_addr = r_a_addr;
    assign o_wr_data = {eff[PIX_W-1:0], r_a_bot};
    assign o_a_adv   = a_adv;
    assign o_top     = eff[2*PIX_W-1:PIX_W];
    assign o_mid     = eff[PIX_W-1:0];
    assign o_bot     = r_a_bot;
    assign o_ctl     = r_a_ctl;

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(i_width))
        else $error("column counter beyond frame width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) <= 32'(i_height) + 32'd1)
        else $error("row counter beyond drain range");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && ctl.frame_last |=> r_col == '0 && r_row == '0 && r_emitted == '0)
        else $error("frame end did not restart counters");

endmodule

### rtl/core/pwg_grad.sv
// Window registers, per-channel gradient, divide by three, clamp and output register.
module pwg_grad
    import pwg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_a_adv,
    input  t_pix      i_top,
    input  t_pix      i_mid,
    input  t_pix      i_bot,
    input  t_edge_ctl i_ctl,
    output logic      o_b_free,
    output logic      o_out_valid,
    output t_out_beat o_out,
    input  logic      i_out_ready
);

    // index = column * 3 + row; columns left, center, right; rows top, mid, bottom
    t_pix      r_win [9];
    logic      r_b_valid;
    t_edge_ctl r_b_ctl;
    logic      r_out_valid;
    t_out_beat r_out, n_out;
    logic      en_o, b_adv;

    assign en_o     = !r_out_valid || i_out_ready;
    assign b_adv    = r_b_valid && en_o;
    assign o_b_free = !r_b_valid || en_o;

    always_ff @(posedge i_clk) begin
        if (i_a_adv) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= r_win[i+3];
            end
            r_win[6] <= i_top;
            r_win[7] <= i_mid;
            r_win[8] <= i_bot;
            r_b_ctl  <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_a_adv) begin
            r_b_valid <= i_ctl.emit;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_comb begin
        t_pix              lt, lm, lb, rt, rm, rb;
        logic [SUM_W-1:0]  sum_l, sum_r, diff;
        logic [PROD_W-1:0] prod;
        logic [CHAN_W-1:0] q [3];
        int                sh;
        lt = r_win[0];
        lm = r_win[1];
        lb = r_win[2];
        rt = r_win[6];
        rm = r_win[7];
        rb = r_win[8];
        // replicate the edge column, then the center row at top and bottom
        if (r_b_ctl.col_left) begin
            lt = r_win[3];
            lm = r_win[4];
            lb = r_win[5];
        end
        if (r_b_ctl.col_right) begin
            rt = r_win[3];
            rm = r_win[4];
            rb = r_win[5];
        end
        if (r_b_ctl.row_top) begin
            lt = lm;
            rt = rm;
        end
        if (r_b_ctl.row_bot) begin
            lb = lm;
            rb = rm;
        end
        for (int k = 0; k < 3; k++) begin
            sh    = (2 - k) * CHAN_W;
            sum_r = SUM_W'(rt[sh +: CHAN_W]) + SUM_W'(rm[sh +: CHAN_W])
                  + SUM_W'(rb[sh +: CHAN_W]);
            sum_l = SUM_W'(lt[sh +: CHAN_W]) + SUM_W'(lm[sh +: CHAN_W])
                  + SUM_W'(lb[sh +: CHAN_W]);
            diff  = (sum_r > sum_l) ? (sum_r - sum_l) : '0;
            prod  = PROD_W'(diff) * PROD_W'(DIV3_MUL);
            q[k]  = prod[DIV3_SHIFT +: CHAN_W];
        end
        n_out.red_out    = q[0];
        n_out.green_out  = q[1];
        n_out.blue_out   = q[2];
        n_out.frame_last = r_b_ctl.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !b_adv |-> !i_a_adv)
        else $error("window shifted under a pending result");

endmodule

### rtl/core/prewitt_horizontal_gradient_rgb.sv
// Top level of the horizontal Prewitt gradient on an RGB raster stream.
// Throughput: one item per cycle unless the output stalls; the dual-port line store reads
// the next entry while the previous one is written back; a same-entry overlap is forwarded.
// Path: stage-A and line-store read registers, window registers, output register; a window
// completes image_width+1 items after its center pixel; drain items push out the last ones.
// Reset: synchronous, active low; counters and pipeline valids clear, registers return
// to 320 x 240. The line store has no clearing pass and takes items right after reset.
module prewitt_horizontal_gradient_rgb
    import pwg_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    input  t_in_beat              i_in,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output t_out_beat             o_out,
    input  logic                  i_out_ready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int EW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [WW-1:0]      width;
    logic [HW-1:0]      height;
    logic [EW-1:0]      total;
    logic               restart;
    logic               b_free, a_adv;
    logic               rd_en, wr_en;
    logic [CW-1:0]      rd_addr, wr_addr;
    logic [2*PIX_W-1:0] rd_data, wr_data;
    t_pix               top, mid, bot;
    t_edge_ctl          ctl;

    pwg_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_width  (width),
        .o_height (height),
        .o_total  (total),
        .o_restart(restart)
    );

    pwg_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DATA_W(2 * PIX_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    pwg_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (width),
        .i_height  (height),
        .i_total   (total),
        .i_restart (restart),
        .i_in_valid(i_in_valid),
        .i_in      (i_in),
        .o_in_ready(o_in_ready),
        .i_b_free  (b_free),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_a_adv   (a_adv),
        .o_top     (top),
        .o_mid     (mid),
        .o_bot     (bot),
        .o_ctl     (ctl)
    );

    pwg_grad u_grad (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_a_adv    (a_adv),
        .i_top      (top),
        .i_mid      (mid),
        .i_bot      (bot),
        .i_ctl      (ctl),
        .o_b_free   (b_free),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_ready(i_out_ready)
    );

endmodule
